// ===== src/sss_pkg.sv =====
// Package for the seven-segment serial frame sender.
// Holds widths, command bytes, opcodes, phase codes, the result struct and the
// character-to-segment encoder. Depends on nothing.
package sss_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int CHAR_COUNT  = 4;
    localparam int CHAR_W      = 8;
    localparam int SEG_W       = 8;
    localparam int WAIT_W      = 8;
    localparam int BRIGHT_W    = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int BIT_CNT_W   = 3;
    localparam int BYTE_IDX_W  = $clog2(DIGIT_COUNT + 3);
    localparam int DIGIT_IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    // last frame byte index: the display-on command
    localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_IDX = BYTE_IDX_W'(DIGIT_COUNT + 2);
    localparam logic [BYTE_IDX_W-1:0] FIRST_DIGIT_IDX = BYTE_IDX_W'(2);

    localparam logic [SEG_W-1:0]  CMD_DATA_SET   = 8'h40;
    localparam logic [SEG_W-1:0]  CMD_ADDR_SET   = 8'hC0;
    localparam logic [SEG_W-1:0]  CMD_DISPLAY_ON = 8'h88;
    localparam logic [WAIT_W-1:0] WAIT_RESET     = 8'd20;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 3'd2;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } sss_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAIT_TICKS = 1'b0,
        CFG_BRIGHTNESS = 1'b1
    } sss_cfg_idx_t;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_S_DHI  = 5'd1,
        PH_S_CHI  = 5'd2,
        PH_S_DLO  = 5'd3,
        PH_S_CLO  = 5'd4,
        PH_B_CLO  = 5'd5,
        PH_B_DAT  = 5'd6,
        PH_B_W1   = 5'd7,
        PH_B_CHI  = 5'd8,
        PH_B_W2   = 5'd9,
        PH_A_CLO  = 5'd10,
        PH_A_REL  = 5'd11,
        PH_A_CHI  = 5'd12,
        PH_A_W    = 5'd13,
        PH_A_CEND = 5'd14,
        PH_P_CLO  = 5'd15,
        PH_P_DLO  = 5'd16,
        PH_P_CHI  = 5'd17,
        PH_P_DHI  = 5'd18
    } sss_phase_t;

    typedef struct packed {
        logic clock_line;
        logic data_line;
        logic busy_res;
        logic load_accepted;
        logic frame_done;
    } sss_res_t;

    function automatic logic [SEG_W-1:0] sss_encode(input logic [CHAR_W-1:0] ch);
        logic [SEG_W-1:0] seg;
        seg = '0;
        case (ch)
            8'h30:   seg = 8'h3F;
            8'h31:   seg = 8'h06;
            8'h32:   seg = 8'h5B;
            8'h33:   seg = 8'h4F;
            8'h34:   seg = 8'h66;
            8'h35:   seg = 8'h6D;
            8'h36:   seg = 8'h7D;
            8'h37:   seg = 8'h07;
            8'h38:   seg = 8'h7F;
            8'h39:   seg = 8'h6F;
            8'h43:   seg = 8'h39;  // 'C'
            8'h4C:   seg = 8'h38;  // 'L'
            8'h4A:   seg = 8'h1E;  // 'J'
            8'h74:   seg = 8'h78;  // 't'
            default: seg = '0;
        endcase
        return seg;
    endfunction

endpackage

// ===== src/sss_ifs.sv =====
// Valid/ready channel interfaces for the serial frame sender.
// Depends on sss_pkg for field widths and the opcode type.
interface sss_cmd_if;
    logic                    valid;
    logic                    ready;
    sss_pkg::sss_op_t        opcode;
    logic [sss_pkg::CHAR_W-1:0] char_0;
    logic [sss_pkg::CHAR_W-1:0] char_1;
    logic [sss_pkg::CHAR_W-1:0] char_2;
    logic [sss_pkg::CHAR_W-1:0] char_3;

    modport source (output valid, opcode, char_0, char_1, char_2, char_3, input ready);
    modport sink   (input valid, opcode, char_0, char_1, char_2, char_3, output ready);
endinterface

interface sss_res_if;
    logic valid;
    logic ready;
    logic clock_line;
    logic data_line;
    logic busy_res;
    logic load_accepted;
    logic frame_done;

    modport source (output valid, clock_line, data_line, busy_res, load_accepted, frame_done,
                    input ready);
    modport sink   (input valid, clock_line, data_line, busy_res, load_accepted, frame_done,
                    output ready);
endinterface

// ===== src/seven_segment_serial_frame_sender.sv =====
// The result of an accepted item is registered in the output register.
// Throughput: one item per cycle; the input is stalled only while a result waits untaken.
// Each item is worked in one pass through the sequencer step logic.
// Reset (rst_n low, asynchronous): idle, both bus lines high, wait_ticks 20, brightness 2.
// The segment store has no reset; a frame starts only after a load fills it.
// Depends on sss_pkg, sss_ifs, sss_seq, sss_out_stage.
module seven_segment_serial_frame_sender (
    input  logic                           clk,
    input  logic                           rst_n,
    sss_cmd_if.sink                        cmd,
    sss_res_if.source                      res,
    input  logic                           cfg_we,
    input  logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sss_pkg::*;

    logic              fire;
    logic              can_take;
    logic [CHAR_W-1:0] chars [CHAR_COUNT];
    sss_res_t          step_res;

    // accept whenever the result register can take the item this step produces
    assign cmd.ready = can_take;
    assign fire      = cmd.valid && can_take;

    // gather the character fields, leftmost first
    assign chars[0] = cmd.char_0;
    assign chars[1] = cmd.char_1;
    assign chars[2] = cmd.char_2;
    assign chars[3] = cmd.char_3;

    // step the frame state machine once per accepted item
    sss_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .opcode    (cmd.opcode),
        .chars     (chars),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (step_res)
    );

    // hold the result item until the sink takes it
    sss_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .res_in   (step_res),
        .can_take (can_take),
        .res      (res)
    );

endmodule

// ===== src/sss_seq.sv =====
// Frame sequencer: configuration registers, segment store and pin-action state machine.
// One accepted item advances the state by one step. Depends on sss_pkg.
module sss_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  sss_pkg::sss_op_t               opcode,
    input  logic [sss_pkg::CHAR_W-1:0]     chars [sss_pkg::CHAR_COUNT],
    input  logic                           cfg_we,
    input  logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0] cfg_data,
    output sss_pkg::sss_res_t              res
);
    import sss_pkg::*;

    logic [WAIT_W-1:0]     wait_ticks_reg;
    logic [BRIGHT_W-1:0]   brightness_reg;
    logic [SEG_W-1:0]      seg_reg [DIGIT_COUNT];

    sss_phase_t            phase_reg, phase_next;
    logic [BYTE_IDX_W-1:0] byte_idx_reg, byte_idx_next;
    logic [SEG_W-1:0]      shift_reg, shift_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [WAIT_W-1:0]     wait_cnt_reg, wait_cnt_next;
    logic                  clk_lvl_reg, clk_lvl_next;
    logic                  dat_lvl_reg, dat_lvl_next;

    logic                  load_go;
    logic                  done;
    logic [WAIT_W-1:0]     eff_wait;
    logic [BYTE_IDX_W-1:0] sel_idx;
    logic [BYTE_IDX_W-1:0] digit_off;
    logic [SEG_W-1:0]      frame_byte;
    logic                  wait_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_ticks_reg <= WAIT_RESET;
            brightness_reg <= BRIGHT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_WAIT_TICKS)
                wait_ticks_reg <= cfg_data[WAIT_W-1:0];
            else
                brightness_reg <= cfg_data[BRIGHT_W-1:0];
        end
    end

    assign load_go   = fire && (opcode == OP_LOAD) && (phase_reg == PH_IDLE);
    assign eff_wait  = (wait_ticks_reg == '0) ? WAIT_W'(1) : wait_ticks_reg;
    assign wait_last = (wait_cnt_reg <= WAIT_W'(1));

    // one read port on the segment store: the byte loaded at the end of an
    // acknowledge is the following one
    assign sel_idx   = (phase_reg == PH_A_CEND) ? byte_idx_reg + BYTE_IDX_W'(1) : byte_idx_reg;
    assign digit_off = sel_idx - FIRST_DIGIT_IDX;

    always_comb
    begin
        if (sel_idx == '0)
            frame_byte = CMD_DATA_SET;
        else if (sel_idx == BYTE_IDX_W'(1))
            frame_byte = CMD_ADDR_SET;
        else if (sel_idx >= FIRST_DIGIT_IDX && sel_idx < LAST_BYTE_IDX)
            frame_byte = seg_reg[digit_off[DIGIT_IDX_W-1:0]];
        else
            frame_byte = CMD_DISPLAY_ON | SEG_W'(brightness_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load_go)
        begin
            for (int i = 0; i < DIGIT_COUNT; i++)
                seg_reg[i] <= (i < CHAR_COUNT) ? sss_encode(chars[i]) : '0;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        byte_idx_next = byte_idx_reg;
        shift_next    = shift_reg;
        bit_cnt_next  = bit_cnt_reg;
        wait_cnt_next = wait_cnt_reg;
        clk_lvl_next  = clk_lvl_reg;
        dat_lvl_next  = dat_lvl_reg;
        done          = 1'b0;

        if (opcode == OP_LOAD)
        begin
            if (phase_reg == PH_IDLE)
            begin
                byte_idx_next = '0;
                bit_cnt_next  = '0;
                wait_cnt_next = '0;
                shift_next    = '0;
                phase_next    = PH_S_DHI;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE: ;
                PH_S_DHI:
                begin
                    dat_lvl_next = 1'b1;
                    phase_next   = PH_S_CHI;
                end
                PH_S_CHI:
                begin
                    clk_lvl_next = 1'b1;
                    phase_next   = PH_S_DLO;
                end
                PH_S_DLO:
                begin
                    dat_lvl_next = 1'b0;
                    phase_next   = PH_S_CLO;
                end
                PH_S_CLO:
                begin
                    clk_lvl_next = 1'b0;
                    shift_next   = frame_byte;
                    bit_cnt_next = '0;
                    phase_next   = PH_B_CLO;
                end
                PH_B_CLO:
                begin
                    clk_lvl_next = 1'b0;
                    phase_next   = PH_B_DAT;
                end
                PH_B_DAT:
                begin
                    dat_lvl_next  = shift_reg[0];
                    wait_cnt_next = eff_wait;
                    phase_next    = PH_B_W1;
                end
                PH_B_W1:
                begin
                    if (wait_last)
                    begin
                        wait_cnt_next = '0;
                        phase_next    = PH_B_CHI;
                    end
                    else
                        wait_cnt_next = wait_cnt_reg - WAIT_W'(1);
                end
                PH_B_CHI:
                begin
                    clk_lvl_next  = 1'b1;
                    wait_cnt_next = eff_wait;
                    phase_next    = PH_B_W2;
                end
                PH_B_W2:
                begin
                    if (wait_last)
                    begin
                        wait_cnt_next = '0;
                        if (bit_cnt_reg == '1)
                        begin
                            bit_cnt_next = '0;
                            phase_next   = PH_A_CLO;
                        end
                        else
                        begin
                            bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                            shift_next   = shift_reg >> 1;
                            phase_next   = PH_B_CLO;
                        end
                    end
                    else
                        wait_cnt_next = wait_cnt_reg - WAIT_W'(1);
                end
                PH_A_CLO:
                begin
                    clk_lvl_next = 1'b0;
                    phase_next   = PH_A_REL;
                end
                PH_A_REL:
                begin
                    dat_lvl_next = 1'b1;
                    phase_next   = PH_A_CHI;
                end
                PH_A_CHI:
                begin
                    clk_lvl_next  = 1'b1;
                    wait_cnt_next = eff_wait;
                    phase_next    = PH_A_W;
                end
                PH_A_W:
                begin
                    if (wait_last)
                    begin
                        wait_cnt_next = '0;
                        phase_next    = PH_A_CEND;
                    end
                    else
                        wait_cnt_next = wait_cnt_reg - WAIT_W'(1);
                end
                PH_A_CEND:
                begin
                    clk_lvl_next = 1'b0;
                    // the address command and every digit but the last chain on
                    if (byte_idx_reg >= BYTE_IDX_W'(1) && byte_idx_reg <= BYTE_IDX_W'(DIGIT_COUNT))
                    begin
                        byte_idx_next = sel_idx;
                        shift_next    = frame_byte;
                        bit_cnt_next  = '0;
                        phase_next    = PH_B_CLO;
                    end
                    else
                        phase_next = PH_P_CLO;
                end
                PH_P_CLO:
                begin
                    clk_lvl_next = 1'b0;
                    phase_next   = PH_P_DLO;
                end
                PH_P_DLO:
                begin
                    dat_lvl_next = 1'b0;
                    phase_next   = PH_P_CHI;
                end
                PH_P_CHI:
                begin
                    clk_lvl_next = 1'b1;
                    phase_next   = PH_P_DHI;
                end
                PH_P_DHI:
                begin
                    dat_lvl_next = 1'b1;
                    if (byte_idx_reg >= LAST_BYTE_IDX)
                    begin
                        byte_idx_next = '0;
                        phase_next    = PH_IDLE;
                        done          = 1'b1;
                    end
                    else
                    begin
                        byte_idx_next = byte_idx_reg + BYTE_IDX_W'(1);
                        phase_next    = PH_S_DHI;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            byte_idx_reg <= '0;
            shift_reg    <= '0;
            bit_cnt_reg  <= '0;
            wait_cnt_reg <= '0;
            clk_lvl_reg  <= 1'b1;
            dat_lvl_reg  <= 1'b1;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            byte_idx_reg <= byte_idx_next;
            shift_reg    <= shift_next;
            bit_cnt_reg  <= bit_cnt_next;
            wait_cnt_reg <= wait_cnt_next;
            clk_lvl_reg  <= clk_lvl_next;
            dat_lvl_reg  <= dat_lvl_next;
        end
    end

    always_comb
    begin
        res.clock_line    = clk_lvl_next;
        res.data_line     = dat_lvl_next;
        res.busy_res      = (phase_next != PH_IDLE);
        res.load_accepted = load_go;
        res.frame_done    = done;
    end

`ifndef SYNTH
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load_go |=> (phase_reg == PH_S_DHI && byte_idx_reg == '0))
        else $error("accepted load did not start a frame");

    a_bit_cnt_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_cnt_reg != '0) |-> (phase_reg == PH_B_CLO || phase_reg == PH_B_DAT ||
                                 phase_reg == PH_B_W1 || phase_reg == PH_B_CHI ||
                                 phase_reg == PH_B_W2))
        else $error("bit count held outside a byte");

    a_wait_cnt_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (wait_cnt_reg != '0) |-> (phase_reg == PH_B_W1 || phase_reg == PH_B_W2 ||
                                  phase_reg == PH_A_W))
        else $error("wait count held outside a wait");

    a_byte_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_idx_reg <= LAST_BYTE_IDX)
        else $error("byte index beyond the frame");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && done) |=> (phase_reg == PH_IDLE && clk_lvl_reg && dat_lvl_reg))
        else $error("frame ended with the bus not released");
`endif

endmodule

// ===== src/sss_out_stage.sv =====
// Result register between the sequencer and the result channel.
// Takes a new item whenever empty or being drained. Depends on sss_pkg, sss_ifs.
module sss_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sss_pkg::sss_res_t res_in,
    output logic              can_take,
    sss_res_if.source         res
);
    import sss_pkg::*;

    logic     valid_reg;
    sss_res_t data_reg;

    assign can_take = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (can_take)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load && can_take)
            data_reg <= res_in;
    end

    assign res.valid         = valid_reg;
    assign res.clock_line    = data_reg.clock_line;
    assign res.data_line     = data_reg.data_line;
    assign res.busy_res      = data_reg.busy_res;
    assign res.load_accepted = data_reg.load_accepted;
    assign res.frame_done    = data_reg.frame_done;

endmodule
